[src/rsba_pkg.sv]
// ----------------------------------------------------------------------------
// rsba_pkg: shared types and constants
// Word width, command and status codes, and the ALU result bundle of the
// reverse-Polish stack ALU.
// ----------------------------------------------------------------------------
package rsba_pkg;

   localparam int WORD_W        = 16;
   localparam int OP_W          = 4;
   localparam int STATUS_W      = 2;
   localparam int STACK_DEPTH   = 16;

   typedef enum logic [OP_W-1:0] {
      OP_ENTER = 4'd0,
      OP_CLEAR = 4'd1,
      OP_POP   = 4'd2,
      OP_TOP   = 4'd3,
      OP_SHL   = 4'd4,
      OP_SHR   = 4'd5,
      OP_OR    = 4'd6,
      OP_AND   = 4'd7,
      OP_ADD   = 4'd8
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [WORD_W-1:0] result;
      logic              overflow;
   } alu_out_type;

endpackage

[src/rsba_if.sv]
// ----------------------------------------------------------------------------
// rsba_req_if / rsba_rsp_if: command and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rsba_req_if;
   logic                        valid;
   logic                        ready;
   logic [rsba_pkg::OP_W-1:0]   operation;
   logic [rsba_pkg::WORD_W-1:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface rsba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          top_present;
   logic [rsba_pkg::WORD_W-1:0]   top_value;
   logic [rsba_pkg::STATUS_W-1:0] status;

   modport source (output valid, output top_present, output top_value,
                   output status, input ready);
   modport sink   (input valid, input top_present, input top_value,
                   input status, output ready);
endinterface

[src/rsba_ram.sv]
// ----------------------------------------------------------------------------
// rsba_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns old data on a
// same-address write.
// ----------------------------------------------------------------------------
module rsba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rsba_alu.sv]
// ----------------------------------------------------------------------------
// rsba_alu: two-operand combining unit
// Shifts, OR, AND and add of the top entry (a) and the one below it (b).
// ----------------------------------------------------------------------------
module rsba_alu (
   input  rsba_pkg::op_type                op,
   input  logic [rsba_pkg::WORD_W-1:0]     a,
   input  logic [rsba_pkg::WORD_W-1:0]     b,
   output rsba_pkg::alu_out_type           res
);

   localparam int SH_W = $clog2(rsba_pkg::WORD_W);

   logic              big_shift;
   logic [SH_W-1:0]   sh_amt;
   logic [rsba_pkg::WORD_W:0] sum;

   // amounts of a full word or more shift everything out
   assign big_shift = (a[rsba_pkg::WORD_W-1:SH_W] != '0);
   assign sh_amt    = a[SH_W-1:0];
   assign sum       = {1'b0, a} + {1'b0, b};

   always_comb begin
      res.overflow = 1'b0;
      unique case (op)
         rsba_pkg::OP_SHL: res.result = big_shift ? '0 : (b << sh_amt);
         rsba_pkg::OP_SHR: res.result = big_shift ? '0 : (b >> sh_amt);
         rsba_pkg::OP_OR:  res.result = a | b;
         rsba_pkg::OP_AND: res.result = a & b;
         rsba_pkg::OP_ADD: begin
            res.result   = sum[rsba_pkg::WORD_W-1:0];
            res.overflow = sum[rsba_pkg::WORD_W];
         end
         default:          res.result = '0;
      endcase
   end

endmodule

[src/rpn_stack_bitwise_alu.sv]
// ----------------------------------------------------------------------------
// rpn_stack_bitwise_alu: 16-bit reverse-Polish stack ALU
// Push, clear, pop, peek and two-operand combine on a word stack; one
// result item per command.
// ----------------------------------------------------------------------------
//  channel  dir  payload                           accepted when
//  req_if   in   operation[3:0], value[15:0]       valid && ready
//  rsp_if   out  top_present, top_value, status    valid && ready
//
//  One command per cycle while results are taken; each result appears the cycle after
//  its command is accepted. Top of stack lives in a register, the entry
//  below it comes from the RAM read port (prefetched, with write bypass),
//  so every command completes in a single pass.
//  req ready is high while the result register is empty or being taken.
//  Reset empties the stack at once; stack storage is not cleared.
// ----------------------------------------------------------------------------
module rpn_stack_bitwise_alu #(
   parameter int STACK_DEPTH = rsba_pkg::STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   rsba_req_if.sink   req_if,
   rsba_rsp_if.source rsp_if
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int W      = rsba_pkg::WORD_W;

   rsba_pkg::op_type      op;
   rsba_pkg::alu_out_type alu_res;

   logic             accept;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [W-1:0]     top_ff, top_in;
   logic [W-1:0]     second;
   logic             full;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [CNT_W-1:0]  rd_cnt;
   logic [W-1:0]      ram_q;
   logic              byp_ff, byp_in;
   logic [W-1:0]      byp_data_ff;

   logic                   rsp_valid_ff;
   logic                   res_present_ff, res_present_in;
   logic [W-1:0]           res_value_ff, res_value_in;
   rsba_pkg::status_type   res_status_ff, res_status_in;

   assign op     = rsba_pkg::op_type'(req_if.operation);
   assign accept = req_if.valid && req_if.ready;
   assign full   = (count_ff == CNT_W'(STACK_DEPTH));
   assign second = byp_ff ? byp_data_ff : ram_q;

   assign req_if.ready       = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.top_present = res_present_ff;
   assign rsp_if.top_value   = res_value_ff;
   assign rsp_if.status      = res_status_ff;

   rsba_alu u_alu (
      .op  (op),
      .a   (top_ff),
      .b   (second),
      .res (alu_res)
   );

   always_comb begin
      count_in       = count_ff;
      top_in         = top_ff;
      wr_en          = 1'b0;
      wr_addr        = ADDR_W'(count_ff - CNT_W'(1));
      res_present_in = 1'b0;
      res_value_in   = '0;
      res_status_in  = rsba_pkg::ST_OK;
      unique case (op) inside
         rsba_pkg::OP_ENTER: begin
            res_present_in = 1'b1;
            if (full) begin
               res_value_in  = top_ff;
               res_status_in = rsba_pkg::ST_FULL;
            end else begin
               // old top drops into RAM below the new one
               wr_en        = accept && (count_ff != '0);
               top_in       = req_if.value;
               count_in     = count_ff + CNT_W'(1);
               res_value_in = req_if.value;
            end
         end
         rsba_pkg::OP_CLEAR: count_in = '0;
         rsba_pkg::OP_POP: begin
            if (count_ff == '0) begin
               res_status_in = rsba_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
               top_in   = second;
               if (count_ff != CNT_W'(1)) begin
                  res_present_in = 1'b1;
                  res_value_in   = second;
               end
            end
         end
         rsba_pkg::OP_TOP: begin
            if (count_ff == '0) begin
               res_status_in = rsba_pkg::ST_EMPTY;
            end else begin
               res_present_in = 1'b1;
               res_value_in   = top_ff;
            end
         end
         rsba_pkg::OP_SHL, rsba_pkg::OP_SHR, rsba_pkg::OP_OR,
         rsba_pkg::OP_AND, rsba_pkg::OP_ADD: begin
            if (count_ff < CNT_W'(2)) begin
               res_status_in = rsba_pkg::ST_EMPTY;
            end else if (alu_res.overflow) begin
               res_status_in = rsba_pkg::ST_OVERFLOW;
            end else begin
               count_in       = count_ff - CNT_W'(1);
               top_in         = alu_res.result;
               res_present_in = 1'b1;
               res_value_in   = alu_res.result;
            end
         end
         default: ;
      endcase
      if (!accept) begin
         count_in = count_ff;
         top_in   = top_ff;
      end
   end

   // prefetch the entry that will sit below the next top
   assign rd_cnt  = count_in - CNT_W'(2);
   assign rd_addr = rd_cnt[ADDR_W-1:0];
   assign byp_in  = wr_en && (wr_addr == rd_addr);

   rsba_ram #(
      .WIDTH (W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
      end else begin
         count_ff <= count_in;
         byp_ff   <= byp_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      top_ff      <= top_in;
      byp_data_ff <= top_ff;
      if (accept) begin
         res_present_ff <= res_present_in;
         res_value_ff   <= res_value_in;
         res_status_ff  <= res_status_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("entry count beyond stack depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      accept && (op == rsba_pkg::OP_ENTER) && !full
      |=> count_ff == CNT_W'($past(count_ff) + CNT_W'(1)))
      else $error("push did not grow the stack");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted command produced no result");

   a_present_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_present_ff
      |-> (res_status_ff == rsba_pkg::ST_OK) || (res_status_ff == rsba_pkg::ST_FULL))
      else $error("top reported with error status");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !res_present_ff |-> res_value_ff == '0)
      else $error("absent top with nonzero value");

endmodule

[tb/rpn_stack_bitwise_alu_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpn_stack_bitwise_alu_tb: self-checking bench for the RPN stack ALU
// Directed checks of the empty, overflow and full-stack corners, then about
// 2000 random commands with random gaps and result stalls. An in-bench stack
// predictor produces the expected item for each accepted command.
// ----------------------------------------------------------------------------
module rpn_stack_bitwise_alu_tb;

   localparam int WORD_W        = rsba_pkg::WORD_W;
   localparam int OP_W          = rsba_pkg::OP_W;
   localparam int STACK_DEPTH   = rsba_pkg::STACK_DEPTH;

   // codes with no command behind them
   localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd9;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_ROUNDS = 10;
   localparam int ROUND_ITEMS   = 200;

   typedef struct packed {
      logic                 present;
      logic [WORD_W-1:0]    value;
      rsba_pkg::status_type status;
   } exp_item_type;

   logic clock;
   logic reset;

   rsba_req_if req_ch ();
   rsba_rsp_if rsp_ch ();

   rpn_stack_bitwise_alu uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // predictor state
   logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
   int                depth;

   exp_item_type pending_results [$];

   int  cycle_count;
   int  mismatch_count;
   int  items_sent;
   int  results_checked;
   int  full_hits;
   int  overflow_hits;
   int  max_depth;
   int  rsp_stall;
   bit  idle_off;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int draw_wait();
      return idle_off ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic exp_item_type peek_item(input rsba_pkg::status_type st);
      exp_item_type r;
      r.present = (depth != 0);
      r.value   = (depth != 0) ? stack_mem[depth-1] : '0;
      r.status  = st;
      return r;
   endfunction

   function automatic exp_item_type stack_alu_step(input logic [OP_W-1:0] op,
                                                   input logic [WORD_W-1:0] val);
      exp_item_type      r;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] res;
      logic [WORD_W:0]   sum;
      r.present = 1'b0;
      r.value   = '0;
      r.status  = rsba_pkg::ST_OK;
      case (op)
         rsba_pkg::OP_ENTER: begin
            if (depth >= STACK_DEPTH) begin
               r = peek_item(rsba_pkg::ST_FULL);
            end else begin
               stack_mem[depth] = val;
               depth++;
               r = peek_item(rsba_pkg::ST_OK);
            end
         end
         rsba_pkg::OP_CLEAR: depth = 0;
         rsba_pkg::OP_POP: begin
            if (depth == 0) begin
               r.status = rsba_pkg::ST_EMPTY;
            end else begin
               depth--;
               r = peek_item(rsba_pkg::ST_OK);
            end
         end
         rsba_pkg::OP_TOP:
            r = peek_item((depth == 0) ? rsba_pkg::ST_EMPTY : rsba_pkg::ST_OK);
         rsba_pkg::OP_SHL, rsba_pkg::OP_SHR, rsba_pkg::OP_OR, rsba_pkg::OP_AND,
         rsba_pkg::OP_ADD: begin
            if (depth < 2) begin
               r.status = rsba_pkg::ST_EMPTY;
            end else begin
               // a is the top entry (shift amount), b the one below it
               a   = stack_mem[depth-1];
               b   = stack_mem[depth-2];
               sum = {1'b0, a} + {1'b0, b};
               case (op)
                  rsba_pkg::OP_SHL: res = (a[WORD_W-1:4] != 0) ? '0 : b << a[3:0];
                  rsba_pkg::OP_SHR: res = (a[WORD_W-1:4] != 0) ? '0 : b >> a[3:0];
                  rsba_pkg::OP_OR:  res = a | b;
                  rsba_pkg::OP_AND: res = a & b;
                  default:          res = sum[WORD_W-1:0];
               endcase
               if (op == rsba_pkg::OP_ADD && sum[WORD_W]) begin
                  r.status = rsba_pkg::ST_OVERFLOW;
               end else begin
                  depth--;
                  stack_mem[depth-1] = res;
                  r = peek_item(rsba_pkg::ST_OK);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_result();
      exp_item_type want;
      if (pending_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result item present=%0b value=%h status=%0d",
                     $realtime, rsp_ch.top_present, rsp_ch.top_value, rsp_ch.status);
      end else begin
         want = pending_results.pop_front();
         results_checked++;
         if (rsp_ch.top_present !== want.present || rsp_ch.top_value !== want.value ||
             rsp_ch.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: mismatch exp present=%0b value=%h status=%0d, got %0b %h %0d",
                        $realtime, want.present, want.value, want.status,
                        rsp_ch.top_present, rsp_ch.top_value, rsp_ch.status);
         end
      end
   endtask

   // results are checked before the command at the same edge is predicted
   always @(posedge clock) begin : monitor
      exp_item_type next_exp;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_result();
         if (req_ch.valid && req_ch.ready) begin
            next_exp        = stack_alu_step(req_ch.operation, req_ch.value);
            pending_results = {pending_results, next_exp};
            if (next_exp.status == rsba_pkg::ST_FULL)
               full_hits++;
            if (next_exp.status == rsba_pkg::ST_OVERFLOW)
               overflow_hits++;
            if (depth > max_depth)
               max_depth = depth;
         end
      end
   end

   // result side: a fresh stall is drawn after each taken item
   always @(posedge clock) begin : rsp_pace
      int gap;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall    <= rsp_stall - 1;
         rsp_ch.ready <= (rsp_stall == 1);
      end else if (!rsp_ch.ready) begin
         rsp_ch.ready <= 1'b1;
      end else if (rsp_ch.valid) begin
         gap = draw_wait();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= gap;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.value     <= val;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      items_sent++;
   endtask

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0, 1, 2: return WORD_W'($urandom_range(0, 17));
         3: begin
            case ($urandom_range(0, 4))
               0:       return 16'h0000;
               1:       return 16'hFFFF;
               2:       return 16'h8000;
               3:       return 16'h7FFF;
               default: return 16'h0001;
            endcase
         end
         default: return WORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input int enter_weight);
      int r;
      if ($urandom_range(0, 99) < enter_weight)
         return rsba_pkg::OP_ENTER;
      r = $urandom_range(0, 99);
      if (r < 70)
         return OP_W'($urandom_range(rsba_pkg::OP_SHL, rsba_pkg::OP_ADD));
      else if (r < 80)
         return rsba_pkg::OP_POP;
      else if (r < 88)
         return rsba_pkg::OP_TOP;
      else if (r < 92)
         return rsba_pkg::OP_CLEAR;
      else
         return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
   endfunction

   task automatic test_empty_stack();
      send_cmd(rsba_pkg::OP_TOP, WORD_W'($urandom));
      send_cmd(rsba_pkg::OP_POP, WORD_W'($urandom));
      send_cmd(rsba_pkg::OP_SHL, WORD_W'($urandom));
      send_cmd(rsba_pkg::OP_ENTER, 16'h0001);
      send_cmd(rsba_pkg::OP_ADD, WORD_W'($urandom));   // one operand only
      send_cmd(rsba_pkg::OP_POP, WORD_W'($urandom));   // pop down to empty
   endtask

   task automatic test_operations();
      send_cmd(rsba_pkg::OP_ENTER, 16'hFFFF);
      send_cmd(rsba_pkg::OP_ENTER, 16'h0001);
      send_cmd(rsba_pkg::OP_ADD, WORD_W'($urandom));   // carry out, operands kept
      send_cmd(rsba_pkg::OP_TOP, WORD_W'($urandom));
      send_cmd(rsba_pkg::OP_ENTER, 16'h0010);
      send_cmd(rsba_pkg::OP_SHL, WORD_W'($urandom));   // amount 16 gives zero
      send_cmd(rsba_pkg::OP_OR, WORD_W'($urandom));
      send_cmd(rsba_pkg::OP_ENTER, 16'h000F);
      send_cmd(rsba_pkg::OP_SHR, WORD_W'($urandom));
      send_cmd(rsba_pkg::OP_ENTER, 16'h8000);
      send_cmd(rsba_pkg::OP_AND, WORD_W'($urandom));
      send_cmd(rsba_pkg::OP_ENTER, 16'h7FFF);
      send_cmd(rsba_pkg::OP_ADD, WORD_W'($urandom));
      send_cmd(rsba_pkg::OP_ENTER, 16'h0000);
      send_cmd(rsba_pkg::OP_SHL, WORD_W'($urandom));
      send_cmd(OP_SPARE_LO, WORD_W'($urandom));
      send_cmd(OP_SPARE_HI, WORD_W'($urandom));
      send_cmd(rsba_pkg::OP_CLEAR, WORD_W'($urandom));
   endtask

   task automatic test_stack_full();
      repeat (STACK_DEPTH) send_cmd(rsba_pkg::OP_ENTER, WORD_W'($urandom));
      send_cmd(rsba_pkg::OP_ENTER, WORD_W'($urandom));  // refused
      send_cmd(rsba_pkg::OP_CLEAR, WORD_W'($urandom));
   endtask

   task automatic test_random_sequences();
      int enter_weight;
      logic [OP_W-1:0] op;
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         case (round % 3)
            0:       enter_weight = 30;
            1:       enter_weight = 45;
            default: enter_weight = 60;
         endcase
         idle_off = (round == 4 || round == 8);
         for (int i = 0; i < ROUND_ITEMS; i++) begin
            op = pick_op(enter_weight);
            send_cmd(op, rand_word());
         end
      end
      idle_off = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = '0;
      req_ch.value     = '0;
      idle_off         = 1'b0;
      depth            = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_stack();
      test_operations();
      test_stack_full();
      test_random_sequences();

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (pending_results.size() != 0) begin
         mismatch_count += pending_results.size();
         $display("%0d expected results never arrived", pending_results.size());
      end
      $display("sent %0d commands, checked %0d results, %0d mismatches",
               items_sent, results_checked, mismatch_count);
      $display("deepest stack %0d, %0d refused pushes, %0d add overflows",
               max_depth, full_hits, overflow_hits);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
